### sv/ep2q_pkg.sv
// ----------------------------------------------------------------------------
// ep2q_pkg
// Shared constants, types and the CORDIC arctangent table for the Euler pose
// to quaternion block.
// ----------------------------------------------------------------------------
package ep2q_pkg;

  localparam int QUAT_FRAC_BITS_DEF = 30;
  localparam int TRIG_BITS          = 30;
  localparam int CORDIC_STEPS       = 30;
  localparam int CORDIC_W           = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Constant division by reciprocal multiplication. 720 = 16 * 45 and
  // 1000 = 8 * 125, so the power of two is shifted off first and the odd
  // factor is divided out in two 24-bit quotient digits.
  localparam int DIV_W  = 52;
  localparam int QUO_W  = 48;
  localparam int DIG_W  = 24;
  localparam int REM_W  = 7;
  localparam int VAL_W  = REM_W + DIG_W;
  localparam int RCP_W  = 32;
  localparam logic [REM_W-1:0] DSR_DEG    = 7'd45;
  localparam logic [REM_W-1:0] DSR_MM     = 7'd125;
  localparam logic [RCP_W-1:0] RCP_DEG    = 32'd3054198967;  // ceil(2^37 / 45)
  localparam logic [RCP_W-1:0] RCP_MM     = 32'd2199023256;  // ceil(2^38 / 125)
  localparam int               RCP_SH_DEG = 37;
  localparam int               RCP_SH_MM  = 38;
  localparam logic [DIV_W-1:0] DEG_ROUND = 52'd360;
  localparam logic [DIV_W-1:0] DEG_BIAS  = 52'd720 << 33;
  localparam logic [DIV_W-1:0] MM_ROUND  = 52'd500;
  localparam logic [DIV_W-1:0] MM_BIAS   = 52'd1000 << 40;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 64;

  typedef logic signed [31:0] trig_t;
  typedef logic signed [MUL_W-1:0] term_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  function automatic logic [31:0] atan_phase(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### sv/ep2q_div.sv
// ----------------------------------------------------------------------------
// ep2q_div
// Division of a 52-bit unsigned dividend by 720 or 1000. The power-of-two
// factor is shifted off, then the odd factor is removed by reciprocal
// multiplication, one 24-bit quotient digit at a time, each digit taking a multiply step and a remainder step.
// ----------------------------------------------------------------------------
module ep2q_div
  import ep2q_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic             sel_mm,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  logic [QUO_W-1:0]   num_r;
  logic [REM_W-1:0]   rem_r;
  logic               sel_r;
  logic               dig_r;
  logic               fix_r;
  logic               busy_r;
  logic               done_r;
  logic [2*RCP_W-1:0] prod_r;

  logic [VAL_W-1:0]   val;
  logic [RCP_W-1:0]   rcp;
  logic [REM_W-1:0]   dsr;
  logic [DIG_W-1:0]   digit;
  logic [VAL_W-1:0]   back;
  logic [QUO_W-1:0]   num_init;

  // Quotient digits shift in at the bottom of num_r as the dividend chunks leave the top.
  always_comb begin
    val      = {rem_r, num_r[QUO_W-1 -: DIG_W]};
    rcp      = sel_r ? RCP_MM : RCP_DEG;
    dsr      = sel_r ? DSR_MM : DSR_DEG;
    digit    = sel_r ? DIG_W'(prod_r >> RCP_SH_MM) : DIG_W'(prod_r >> RCP_SH_DEG);
    back     = VAL_W'(digit) * VAL_W'(dsr);
    num_init = sel_mm ? dividend[DIV_W-2 -: QUO_W] : dividend[DIV_W-1 -: QUO_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      fix_r  <= 1'b0;
      dig_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num_init;
        rem_r  <= '0;
        sel_r  <= sel_mm;
        dig_r  <= 1'b0;
        fix_r  <= 1'b0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!fix_r) begin
          prod_r <= 64'(val) * 64'(rcp);
          fix_r  <= 1'b1;
        end else begin
          rem_r <= REM_W'(val - back);
          num_r <= {num_r[QUO_W-DIG_W-1:0], digit};
          fix_r <= 1'b0;
          dig_r <= 1'b1;
          if (dig_r) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

### sv/ep2q_cordic.sv
// ----------------------------------------------------------------------------
// ep2q_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, returning the
// cosine and sine in Q30 of a 32-bit phase where 2^32 is one full turn.
// ----------------------------------------------------------------------------
module ep2q_cordic
  import ep2q_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] phase,
  output logic        done,
  output trig_t       cos_o,
  output trig_t       sin_o
);

  logic signed [CORDIC_W-1:0] x_r, y_r;
  logic signed [32:0]         z_r;
  logic [4:0]                 i_r;
  logic [1:0]                 quad_r;
  logic                       busy_r, fin_r, done_r;
  trig_t                      cos_r, sin_r;

  logic [31:0]                qd, ru;
  logic signed [CORDIC_W-1:0] xs, ys, xc, yc;
  logic signed [32:0]         at;

  localparam logic signed [CORDIC_W-1:0] ONE = 34'sd1 <<< TRIG_BITS;

  always_comb begin
    qd = phase + 32'h2000_0000;
    ru = phase - {qd[31:30], 30'd0};
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = 33'(atan_phase(i_r));
    xc = (x_r > ONE) ? ONE : ((x_r < -ONE) ? -ONE : x_r);
    yc = (y_r > ONE) ? ONE : ((y_r < -ONE) ? -ONE : y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (start) begin
        quad_r <= qd[31:30];
        z_r    <= 33'(signed'(ru));
        x_r    <= CORDIC_GAIN;
        y_r    <= '0;
        i_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!z_r[32]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end
        i_r <= i_r + 5'd1;
        if (i_r == 5'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        // Rotate the first-quadrant result back by the quadrant taken off at start.
        case (quad_r)
          2'd0: begin cos_r <= 32'(xc);  sin_r <= 32'(yc);  end
          2'd1: begin cos_r <= 32'(-yc); sin_r <= 32'(xc);  end
          2'd2: begin cos_r <= 32'(-xc); sin_r <= 32'(-yc); end
          default: begin cos_r <= 32'(yc); sin_r <= 32'(-xc); end
        endcase
        done_r <= 1'b1;
      end
    end
  end

  assign done  = done_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

### sv/euler_pose_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_pose_to_quaternion
// Converts one arm sample (position in mm, heading/attitude/bank in degrees)
// to a position in metres and a z-x-z quaternion, dropping repeated poses.
//
//   channel | direction | payload
//   in_     | slave     | stamp, position mm, three angles
//   out_    | master    | stamp, quaternion x,y,z,w, position m
//
// One request runs through the accept state, six constant divisions in the
// shared divider, three CORDIC runs, eight passes through the shared 34x34
// multiplier, the angle sum term step and the compare step.
// in_tready is high only while the sequencer is idle. A pending result is held
// in the output register; the next request is taken meanwhile and stalls only
// at its final compare until the output is free. Reset loads the identity pose.
// ----------------------------------------------------------------------------
module euler_pose_to_quaternion
  import ep2q_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // time_stamp[62:0], pos_x_mm, pos_y_mm, pos_z_mm, heading_deg, attitude_deg,
  // bank_deg (32 bits each), one zero pad bit
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_stamp[62:0], quat_x, quat_y, quat_z, quat_w (32 bits each),
  // pos_x_m, pos_y_m, pos_z_m (40 bits each), one zero pad bit
  output logic [311:0] out_tdata
);

  localparam int FS = 2 * TRIG_BITS - QUAT_FRAC_BITS;
  localparam prod_t LIM = prod_t'(1) <<< QUAT_FRAC_BITS;
  localparam prod_t HALF_FS = prod_t'(1) <<< (FS - 1);
  localparam prod_t HALF_T = prod_t'(1) <<< (TRIG_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_GO, S_DIV_WAIT, S_COR_GO, S_COR_WAIT, S_MUL, S_ACC, S_TERM, S_CMP
  } state_t;

  state_t               state_r;
  logic [2:0]           job_r;
  logic [62:0]          stamp_r;
  logic signed [31:0]   pin_r [3];
  logic signed [31:0]   ang_r [3];
  logic [31:0]          phase_r [3];
  logic signed [39:0]   pos_r [3];
  trig_t                cos_r [3];
  trig_t                sin_r [3];
  prod_t                prod_r;
  prod_t                pp_r [4];
  term_t                term_r [4];
  logic signed [31:0]   q_r [4];
  logic signed [31:0]   last_q_r [4];
  logic signed [39:0]   last_p_r [3];
  logic                 out_tvalid_r;
  logic [311:0]         out_tdata_r;

  logic                 div_start, div_done;
  logic [DIV_W-1:0]     div_dividend;
  logic [QUO_W-1:0]     div_quot;
  logic                 div_sel_mm;
  logic                 cor_start, cor_done;
  trig_t                cor_cos, cor_sin;
  logic signed [DIV_W-1:0] div_src;
  term_t                mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_full;
  prod_t                rnd_v, rnd_s;
  logic signed [31:0]   rnd_q;
  logic                 same;
  logic                 emit;

  assign in_tready = (state_r == S_IDLE);
  assign div_start = (state_r == S_DIV_GO);
  assign cor_start = (state_r == S_COR_GO);
  assign emit      = (state_r == S_CMP) && !same && (!out_tvalid_r || out_tready);

  // Jobs 0..2 turn the angles into half-angle phases, jobs 3..5 scale the position.
  always_comb begin
    if (job_r < 3'd3) begin
      div_src      = DIV_W'(ang_r[job_r[1:0]]);
      div_dividend = DIV_W'(div_src <<< 11) + DEG_ROUND + DEG_BIAS;
      div_sel_mm   = 1'b0;
    end else begin
      div_src      = DIV_W'(pin_r[2'(job_r - 3'd3)]);
      div_dividend = DIV_W'(div_src <<< 16) + MM_ROUND + MM_BIAS;
      div_sel_mm   = 1'b1;
    end
  end

  always_comb begin
    case (job_r)
      3'd0: begin mul_a = MUL_W'(cos_r[0]); mul_b = MUL_W'(cos_r[2]); end
      3'd1: begin mul_a = MUL_W'(sin_r[0]); mul_b = MUL_W'(sin_r[2]); end
      3'd2: begin mul_a = MUL_W'(sin_r[0]); mul_b = MUL_W'(cos_r[2]); end
      3'd3: begin mul_a = MUL_W'(cos_r[0]); mul_b = MUL_W'(sin_r[2]); end
      3'd4: begin mul_a = MUL_W'(sin_r[1]); mul_b = term_r[2]; end
      3'd5: begin mul_a = MUL_W'(sin_r[1]); mul_b = term_r[3]; end
      3'd6: begin mul_a = MUL_W'(cos_r[1]); mul_b = term_r[1]; end
      default: begin mul_a = MUL_W'(cos_r[1]); mul_b = term_r[0]; end
    endcase
    mul_full = mul_a * mul_b;
  end

  always_comb begin
    rnd_v = prod_r + HALF_FS;
    rnd_s = rnd_v >>> FS;
    if (rnd_s > LIM) begin
      rnd_q = 32'(LIM);
    end else if (rnd_s < -LIM) begin
      rnd_q = 32'(-LIM);
    end else begin
      rnd_q = 32'(rnd_s);
    end
  end

  always_comb begin
    same = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (q_r[k] != last_q_r[k]) same = 1'b0;
    end
    for (int k = 0; k < 3; k++) begin
      if (pos_r[k] != last_p_r[k]) same = 1'b0;
    end
  end

  ep2q_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .sel_mm   (div_sel_mm),
    .done     (div_done),
    .quotient (div_quot)
  );

  ep2q_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .phase (phase_r[job_r[1:0]]),
    .done  (cor_done),
    .cos_o (cor_cos),
    .sin_o (cor_sin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      job_r        <= '0;
      out_tvalid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        last_q_r[k] <= '0;
        last_p_r[k] <= '0;
      end
      last_q_r[3] <= 32'(LIM);
    end else begin
      if (out_tvalid_r && out_tready && !emit) out_tvalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            stamp_r  <= in_tdata[62:0];
            pin_r[0] <= in_tdata[94:63];
            pin_r[1] <= in_tdata[126:95];
            pin_r[2] <= in_tdata[158:127];
            ang_r[0] <= in_tdata[190:159];
            ang_r[1] <= in_tdata[222:191];
            ang_r[2] <= in_tdata[254:223];
            job_r    <= '0;
            state_r  <= S_DIV_GO;
          end
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            if (job_r < 3'd3) begin
              phase_r[job_r[1:0]] <= div_quot[31:0];
            end else begin
              pos_r[2'(job_r - 3'd3)] <= div_quot[39:0];
            end
            if (job_r == 3'd5) begin
              job_r   <= '0;
              state_r <= S_COR_GO;
            end else begin
              job_r   <= job_r + 3'd1;
              state_r <= S_DIV_GO;
            end
          end
        end
        S_COR_GO: state_r <= S_COR_WAIT;
        S_COR_WAIT: begin
          if (cor_done) begin
            cos_r[job_r[1:0]] <= cor_cos;
            sin_r[job_r[1:0]] <= cor_sin;
            if (job_r == 3'd2) begin
              job_r   <= '0;
              state_r <= S_MUL;
            end else begin
              job_r   <= job_r + 3'd1;
              state_r <= S_COR_GO;
            end
          end
        end
        S_MUL: begin
          prod_r  <= mul_full[PROD_W-1:0];
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (job_r < 3'd4) begin
            pp_r[job_r[1:0]] <= prod_r;
          end else begin
            q_r[job_r[1:0]] <= rnd_q;
          end
          if (job_r == 3'd3) begin
            state_r <= S_TERM;
          end else if (job_r == 3'd7) begin
            state_r <= S_CMP;
          end else begin
            job_r   <= job_r + 3'd1;
            state_r <= S_MUL;
          end
        end
        S_TERM: begin
          // Angle sum and difference terms, rounded to Q30.
          term_r[0] <= MUL_W'((pp_r[0] - pp_r[1] + HALF_T) >>> TRIG_BITS);
          term_r[1] <= MUL_W'((pp_r[2] + pp_r[3] + HALF_T) >>> TRIG_BITS);
          term_r[2] <= MUL_W'((pp_r[0] + pp_r[1] + HALF_T) >>> TRIG_BITS);
          term_r[3] <= MUL_W'((pp_r[2] - pp_r[3] + HALF_T) >>> TRIG_BITS);
          job_r     <= 3'd4;
          state_r   <= S_MUL;
        end
        S_CMP: begin
          if (same) begin
            job_r   <= '0;
            state_r <= S_IDLE;
          end else if (emit) begin
            for (int k = 0; k < 4; k++) last_q_r[k] <= q_r[k];
            for (int k = 0; k < 3; k++) last_p_r[k] <= pos_r[k];
            out_tdata_r  <= {1'b0, pos_r[2], pos_r[1], pos_r[0],
                             q_r[3], q_r[2], q_r[1], q_r[0], stamp_r};
            out_tvalid_r <= 1'b1;
            job_r        <= '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Euler pose to quaternion converter. A queue of
// arm samples (directed corner cases, then random poses with repeats) is fed
// into the input stream. Each accepted request runs through a bit-exact
// software copy of the fixed-point path: CORDIC sine and cosine, the z-x-z
// product and the mm to m scaling. The result stream is checked field by
// field against the queue of predicted poses. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import ep2q_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QBITS = QUAT_FRAC_BITS_DEF;
  localparam int N_RANDOM = 1800;
  localparam int IDLE_PCT = 32;

  typedef struct {
    logic [62:0]        stamp;
    logic signed [31:0] pmm[3];
    logic signed [31:0] ang[3];   // heading, attitude, bank
    bit                 drain;    // wait for all results before sending
  } sample_t;

  typedef struct {
    logic [62:0]        stamp;
    logic signed [31:0] quat[4];  // x, y, z, w
    logic signed [39:0] pm[3];
  } pose_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [311:0] out_tdata;

  euler_pose_to_quaternion dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_t pending[$];
  pose_t   expected_poses[$];
  sample_t cur_sample;
  int      n_sent = 0;
  int      n_taken = 0;
  int      n_errors = 0;
  int      stall_left = 0;
  bit      stall_done = 1'b0;

  longint  held_quat[4];
  longint  held_pos[3];

  const string QNAME[4] = '{"x", "y", "z", "w"};
  const string PNAME[3] = '{"x", "y", "z"};

  const longint atan_tab[30] = '{
    'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
    'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
    'h00000028, 'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001};

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Half-angle phase: 2^32 is one turn of the half angle, ties round up.
  function automatic logic [31:0] half_phase(logic signed [31:0] a);
    longint t;
    t = longint'(a) * 2048 + 360 + 720 * (64'sd1 <<< 43);
    return 32'(t / 720);
  endfunction

  function automatic void cordic_sin_cos(input logic [31:0] ph,
                                         output longint c, output longint s);
    logic [31:0] t;
    logic [1:0]  quad;
    logic [31:0] res;
    longint      x, y, z, nx;
    t = ph + 32'h20000000;
    quad = t[31:30];
    res = ph - {quad, 30'b0};
    z = longint'($signed(res));
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
      end
      x = nx;
    end
    x = clip(x, 64'sd1 <<< 30);
    y = clip(y, 64'sd1 <<< 30);
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint mm_to_metres(logic signed [31:0] raw);
    longint t;
    t = longint'(raw) * 65536 + 500 + 1000 * (64'sd1 <<< 48);
    return t / 1000 - (64'sd1 <<< 48);
  endfunction

  // Updates the held pose and queues a result unless the pose repeats.
  function automatic void predict_pose(sample_t smp);
    longint ch, sh, ca, sa, cb, sb, sum_c, sum_s, dif_c, dif_s;
    longint q[4], p[3];
    longint lim;
    bit     same;
    pose_t  r;
    lim = 64'sd1 <<< QBITS;
    cordic_sin_cos(half_phase(smp.ang[0]), ch, sh);
    cordic_sin_cos(half_phase(smp.ang[1]), ca, sa);
    cordic_sin_cos(half_phase(smp.ang[2]), cb, sb);
    sum_c = round_shift(ch * cb - sh * sb, 30);
    sum_s = round_shift(sh * cb + ch * sb, 30);
    dif_c = round_shift(ch * cb + sh * sb, 30);
    dif_s = round_shift(sh * cb - ch * sb, 30);
    q[0] = clip(round_shift(sa * dif_c, 60 - QBITS), lim);
    q[1] = clip(round_shift(sa * dif_s, 60 - QBITS), lim);
    q[2] = clip(round_shift(ca * sum_s, 60 - QBITS), lim);
    q[3] = clip(round_shift(ca * sum_c, 60 - QBITS), lim);
    for (int k = 0; k < 3; k++) p[k] = mm_to_metres(smp.pmm[k]);
    same = 1'b1;
    for (int k = 0; k < 4; k++) if (q[k] != held_quat[k]) same = 1'b0;
    for (int k = 0; k < 3; k++) if (p[k] != held_pos[k]) same = 1'b0;
    if (same) return;
    r.stamp = smp.stamp;
    for (int k = 0; k < 4; k++) begin
      held_quat[k] = q[k];
      r.quat[k] = 32'(q[k]);
    end
    for (int k = 0; k < 3; k++) begin
      held_pos[k] = p[k];
      r.pm[k] = 40'(p[k]);
    end
    expected_poses.push_back(r);
  endfunction

  function automatic logic [255:0] pack_sample(sample_t smp);
    return {1'b0, smp.ang[2], smp.ang[1], smp.ang[0],
            smp.pmm[2], smp.pmm[1], smp.pmm[0], smp.stamp};
  endfunction

  function automatic sample_t make_sample(logic signed [31:0] x, logic signed [31:0] y,
                                          logic signed [31:0] z, logic signed [31:0] h,
                                          logic signed [31:0] a, logic signed [31:0] b);
    sample_t smp;
    smp.stamp = 63'({$urandom, $urandom});
    smp.pmm = '{x, y, z};
    smp.ang = '{h, a, b};
    smp.drain = 1'b0;
    return smp;
  endfunction

  function automatic logic signed [31:0] deg(int d);
    return 32'(longint'(d) <<< 21);
  endfunction

  // Idling is switched off for a stretch in the middle of the run.
  function automatic bit idle_now();
    if (n_taken >= 900 && n_taken < 1200) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // Request driver.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || n_taken == n_sent)) begin
      if (pending.size() != 0 && !(pending[0].drain && expected_poses.size() != 0)
          && !idle_now()) begin
        cur_sample = pending.pop_front();
        in_tdata <= pack_sample(cur_sample);
        in_tvalid <= 1'b1;
        n_sent++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_pose(cur_sample);
      n_taken++;
    end
  end

  // Result receiver; one long hold-off lets the block back up into its input.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!stall_done && n_taken == 300) begin
        stall_done = 1'b1;
        stall_left = 3000;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !idle_now();
      end
    end
  end

  always @(posedge clk) begin
    pose_t exp_r;
    logic signed [31:0] got_q[4];
    logic signed [39:0] got_p[3];
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_poses.size() == 0) begin
        $error("unexpected result, stamp %0h", out_tdata[62:0]);
        n_errors++;
      end else begin
        exp_r = expected_poses.pop_front();
        for (int k = 0; k < 4; k++) got_q[k] = out_tdata[63 + 32*k +: 32];
        for (int k = 0; k < 3; k++) got_p[k] = out_tdata[191 + 40*k +: 40];
        if (out_tdata[62:0] !== exp_r.stamp) begin
          $error("out_stamp: expected %0h, got %0h", exp_r.stamp, out_tdata[62:0]);
          n_errors++;
        end
        for (int k = 0; k < 4; k++) begin
          if (got_q[k] !== exp_r.quat[k]) begin
            $error("quat_%s: expected %0d, got %0d", QNAME[k],
                   exp_r.quat[k], got_q[k]);
            n_errors++;
          end
        end
        for (int k = 0; k < 3; k++) begin
          if (got_p[k] !== exp_r.pm[k]) begin
            $error("pos_%s_m: expected %0d, got %0d", PNAME[k],
                   exp_r.pm[k], got_p[k]);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    sample_t smp;
    sample_t prev;
    int      pick;
    held_quat = '{0, 0, 0, 64'sd1 <<< QBITS};
    held_pos = '{0, 0, 0};

    // The zero pose matches the identity held after reset and is dropped.
    pending.push_back(make_sample(0, 0, 0, 0, 0, 0));
    smp = make_sample(32'sh7fffffff, 32'sh80000000, 1, deg(90), deg(45), deg(-90));
    smp.stamp = '1;
    pending.push_back(smp);
    smp.stamp = '0;   // same pose again, only the stamp differs
    pending.push_back(smp);
    pending.push_back(make_sample(32'sh80000000, 32'sh7fffffff, -1,
                                  32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
    pending.push_back(make_sample(-1, 0, 32'sh7fffffff,
                                  32'sh80000000, 32'sh7fffffff, 32'sh80000000));
    pending.push_back(make_sample(0, 0, 0, deg(180), deg(180), deg(180)));
    pending.push_back(make_sample(0, 0, 0, deg(360), deg(0), deg(-360)));
    pending.push_back(make_sample(0, 0, 0, deg(720), deg(720), deg(720)));
    pending.push_back(make_sample(500, -500, 1500, deg(-180), deg(90), deg(270)));
    pending.push_back(make_sample(0, 0, 0, deg(45), deg(-45), deg(135)));
    pending.push_back(make_sample(0, 0, 0, 1, -1, 1));
    smp = make_sample(0, 0, 0, 0, 0, 0);
    smp.drain = 1'b1;   // back to identity after the pipe has emptied
    pending.push_back(smp);
    pending.push_back(make_sample(0, 0, 0, 0, 0, 0));
    prev = smp;

    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        smp = prev;
        smp.stamp = 63'({$urandom, $urandom});
      end else if (pick < 60) begin
        smp = make_sample($urandom_range(0, 2000000) - 1000000,
                          $urandom_range(0, 2000000) - 1000000,
                          $urandom_range(0, 2000000) - 1000000,
                          $urandom_range(0, 1509949440) - 754974720,
                          $urandom_range(0, 1509949440) - 754974720,
                          $urandom_range(0, 1509949440) - 754974720);
      end else if (pick < 70) begin
        smp = make_sample($urandom, $urandom, $urandom,
                          deg(45 * $urandom_range(0, 16) - 360),
                          deg(45 * $urandom_range(0, 16) - 360),
                          deg(45 * $urandom_range(0, 16) - 360));
      end else begin
        smp = make_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      smp.drain = (i == 1500);
      pending.push_back(smp);
      prev = smp;
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    wait (pending.size() == 0 && n_taken == n_sent);
    wait (expected_poses.size() == 0);
    repeat (400) @(posedge clk);
    if (n_errors == 0 && expected_poses.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
